// File: design/ppa_pkg.sv
// Shared types, constants and table functions of the plane phasor accumulator.
`timescale 1ns / 1ps
`default_nettype none
package ppa_pkg;

    // Default sizes of the plane and of the phase table.
    localparam int MAX_CELLS_I_DEF   = 64;
    localparam int MAX_CELLS_J_DEF   = 64;
    localparam int PHASE_ENTRIES_DEF = 1024;

    // Queue depths between the parts.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP    = 2'd0,
        REG_INVERSE_STEPS = 2'd1
    } t_cfg_reg;

    localparam logic [31:0] PHASE_STEP_RST    = 32'h0000_0000;
    localparam logic [31:0] INVERSE_STEPS_RST = 32'hFFFF_FFFF;

    // Constants of the quarter-wave series: 2*pi in Q3.29 and the term divisors.
    localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;
    localparam int SERIES_TERMS = 9;
    localparam longint unsigned SIN_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};
    localparam longint unsigned COS_DIV [SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306};

    // Input word.
    typedef struct packed {
        logic        [23:0] time_index;
        logic        [1:0]  component;
        logic        [6:0]  cell_i;
        logic        [6:0]  cell_j;
        logic signed [31:0] first_part;
        logic signed [31:0] second_part;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic        [1:0]  out_component;
        logic        [6:0]  out_cell_i;
        logic        [6:0]  out_cell_j;
        logic signed [31:0] sum_real;
        logic signed [31:0] sum_imag;
        logic               saturated;
    } t_out_word;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [31:0] phase_step;
        logic [31:0] inverse_steps;
    } t_cfg;

    // Identity of an item as it moves through the back pipeline.
    typedef struct packed {
        logic [1:0] component;
        logic [6:0] cell_i;
        logic [6:0] cell_j;
        logic       in_range;
    } t_tag;

    // Classified word handed from the front part to the back part.
    typedef struct packed {
        t_tag        tag;
        logic        neg;
        logic [32:0] mag;
        logic [31:0] phase;
    } t_work;

    // Round a Q2.30 value half up to Q1.15 and clip it to [0, 32767].
    function automatic logic [15:0] to_q15(longint v);
        longint unsigned r;
        if (v < 0) begin
            r = 64'd0;
        end else begin
            r = (64'(v) + 64'd16384) >> 15;
        end
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    // Cosine and sine of a first-quadrant angle, returned as {cos, sin}.
    function automatic logic [31:0] quarter_trig(logic [29:0] r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned st;
        longint unsigned ct;
        longint          ssum;
        longint          csum;
        x  = (64'(r) * TWO_PI_Q29 + (64'd1 << 30)) >> 31;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        st = x;
        ct = 64'd1 << 30;
        ssum = longint'(x);
        csum = longint'(64'd1 << 30);
        for (int n = 0; n < SERIES_TERMS; n++) begin
            st = ((st * x2) >> 30) / SIN_DIV[n];
            ct = ((ct * x2) >> 30) / COS_DIV[n];
            // Terms at even n subtract, terms at odd n add.
            if ((n & 1) == 0) begin
                ssum = ssum - longint'(st);
                csum = csum - longint'(ct);
            end else begin
                ssum = ssum + longint'(st);
                csum = csum + longint'(ct);
            end
        end
        return {to_q15(csum), to_q15(ssum)};
    endfunction

    // Table entry for a phase given as a 32-bit turn fraction.
    function automatic logic [31:0] trig_entry(longint unsigned t);
        logic [31:0] cs;
        logic [15:0] c;
        logic [15:0] s;
        logic [31:0] res;
        cs = quarter_trig(t[29:0]);
        c  = cs[31:16];
        s  = cs[15:0];
        case (t[31:30])
            2'd0:    res = {c, s};
            2'd1:    res = {16'(-s), c};
            2'd2:    res = {16'(-c), 16'(-s)};
            default: res = {s, 16'(-c)};
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/ppa_fifo.sv
// Small register queue used between the front part, the back part and the result port.
`timescale 1ns / 1ps
`default_nettype none
module ppa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic [WIDTH-1:0]                  o_data,
    output logic                              o_empty,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: design/ppa_front.sv
// Front part: classifies an input word and forms its phase and sample magnitude.
`timescale 1ns / 1ps
`default_nettype none
module ppa_front #(
    parameter int MAX_CELLS_I = ppa_pkg::MAX_CELLS_I_DEF,
    parameter int MAX_CELLS_J = ppa_pkg::MAX_CELLS_J_DEF
) (
    input  wire ppa_pkg::t_in_word i_word,
    input  wire logic [31:0]       i_phase_step,
    output ppa_pkg::t_work         o_work
);
    logic signed [32:0] w_sum;
    logic [63:0]        w_phase_prod;

    // Exact sum of the two split-field parts, then sign and magnitude.
    assign w_sum = 33'(i_word.first_part) + 33'(i_word.second_part);

    // Phase is the low word of time index times phase step.
    assign w_phase_prod = 64'(i_word.time_index) * 64'(i_phase_step);

    always_comb begin
        o_work.tag.component = i_word.component;
        o_work.tag.cell_i    = i_word.cell_i;
        o_work.tag.cell_j    = i_word.cell_j;
        o_work.tag.in_range  = (32'(i_word.cell_i) <= 32'(MAX_CELLS_I)) &&
                               (32'(i_word.cell_j) <= 32'(MAX_CELLS_J));
        o_work.neg           = w_sum[32];
        o_work.mag           = w_sum[32] ? 33'(-w_sum) : 33'(w_sum);
        o_work.phase         = w_phase_prod[31:0];
    end
endmodule
`default_nettype wire

// File: design/ppa_back.sv
// Back part: table lookup, scaling and saturating read-modify-write of the accumulators.
`timescale 1ns / 1ps
`default_nettype none
module ppa_back #(
    parameter int MAX_CELLS_I   = ppa_pkg::MAX_CELLS_I_DEF,
    parameter int MAX_CELLS_J   = ppa_pkg::MAX_CELLS_J_DEF,
    parameter int PHASE_ENTRIES = ppa_pkg::PHASE_ENTRIES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [31:0]                            i_inverse_steps,
    input  wire ppa_pkg::t_work                         i_work,
    input  wire logic                                   i_work_empty,
    output logic                                        o_work_pop,
    input  wire logic [$clog2(ppa_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                        o_out_push,
    output ppa_pkg::t_out_word                          o_out_word,
    output logic                                        o_clearing
);
    localparam int SPAN_I      = MAX_CELLS_I + 1;
    localparam int SPAN_J      = MAX_CELLS_J + 1;
    localparam int STORE_DEPTH = 4 * SPAN_I * SPAN_J;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int IW          = $clog2(PHASE_ENTRIES);
    localparam int OCW         = $clog2(ppa_pkg::OUT_DEPTH + 1);

    // Phase table, built from constants at elaboration.
    logic [31:0] w_rom [PHASE_ENTRIES];
    for (genvar k = 0; k < PHASE_ENTRIES; k++) begin : g_rom
        localparam longint unsigned LP_T = (64'(k) << 32) / PHASE_ENTRIES;
        assign w_rom[k] = ppa_pkg::trig_entry(LP_T);
    end

    // Accumulator memory: real part in the upper word.
    logic [63:0] r_store [STORE_DEPTH];

    logic               r_clr_active;
    logic [AW-1:0]      r_clr_addr;

    logic               w_issue;
    logic [OCW:0]       w_load;
    logic [AW-1:0]      w_slot0;
    logic [63:0]        w_idx_prod;

    // Stage 1: magnitude product and table read.
    logic               r1_valid;
    ppa_pkg::t_tag      r1_tag;
    logic [AW-1:0]      r1_slot;
    logic               r1_neg;
    logic [64:0]        r1_prod;
    logic [31:0]        r1_trig;
    logic [65:0]        w1_round;
    logic signed [15:0] w1_cos;
    logic signed [15:0] w1_sin;

    // Stage 2: scaled magnitude and trig magnitudes.
    logic               r2_valid;
    ppa_pkg::t_tag      r2_tag;
    logic [AW-1:0]      r2_slot;
    logic [32:0]        r2_mag;
    logic [15:0]        r2_cos_mag;
    logic [15:0]        r2_sin_mag;
    logic               r2_re_neg;
    logic               r2_im_neg;
    logic [48:0]        w2_re_prod;
    logic [48:0]        w2_im_prod;

    // Stage 3: accumulate, clamp and write back.
    logic               r3_valid;
    ppa_pkg::t_tag      r3_tag;
    logic [AW-1:0]      r3_slot;
    logic [32:0]        r3_re_term;
    logic [32:0]        r3_im_term;
    logic               r3_re_neg;
    logic               r3_im_neg;
    logic [63:0]        r3_rd_data;
    logic               r3_fwd;
    logic [63:0]        r_last_wr;
    logic [63:0]        w3_acc;
    logic signed [34:0] w3_re;
    logic signed [34:0] w3_im;
    logic [31:0]        w3_re_sat;
    logic [31:0]        w3_im_sat;
    logic               w3_re_clip;
    logic               w3_im_clip;
    logic               w3_write;

    // Issue an item only when the result queue has room for everything in flight.
    assign w_load     = (OCW+1)'(i_out_count) + (OCW+1)'(r1_valid) + (OCW+1)'(r2_valid)
                      + (OCW+1)'(r3_valid);
    assign w_issue    = !i_work_empty && !r_clr_active &&
                        (w_load < (OCW+1)'(ppa_pkg::OUT_DEPTH));
    assign o_work_pop = w_issue;
    assign o_clearing = r_clr_active;

    // Store address and table index of the issued item.
    assign w_slot0    = (AW'(i_work.tag.component) * AW'(SPAN_I) + AW'(i_work.tag.cell_i))
                      * AW'(SPAN_J) + AW'(i_work.tag.cell_j);
    assign w_idx_prod = 64'(i_work.phase) * 64'(PHASE_ENTRIES);

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= w_issue;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        r1_tag  <= i_work.tag;
        r1_slot <= w_slot0;
        r1_neg  <= i_work.neg;
        r1_prod <= 65'(i_work.mag) * 65'(i_inverse_steps);
        r1_trig <= w_rom[w_idx_prod[32+IW-1:32]];
    end

    // Round the magnitude half up and split the trig values into sign and size.
    assign w1_round = 66'(r1_prod) + (66'd1 << 31);
    assign w1_cos   = r1_trig[31:16];
    assign w1_sin   = r1_trig[15:0];

    always_ff @(posedge i_clk) begin
        r2_tag     <= r1_tag;
        r2_slot    <= r1_slot;
        r2_mag     <= w1_round[64:32];
        r2_cos_mag <= w1_cos[15] ? 16'(-w1_cos) : 16'(w1_cos);
        r2_sin_mag <= w1_sin[15] ? 16'(-w1_sin) : 16'(w1_sin);
        r2_re_neg  <= r1_neg ^ w1_cos[15];
        r2_im_neg  <= r1_neg ^ w1_sin[15];
    end

    // Scale by cosine and sine with rounding of the Q1.15 product.
    assign w2_re_prod = 49'(r2_mag) * 49'(r2_cos_mag) + 49'd16384;
    assign w2_im_prod = 49'(r2_mag) * 49'(r2_sin_mag) + 49'd16384;

    always_ff @(posedge i_clk) begin
        r3_tag     <= r2_tag;
        r3_slot    <= r2_slot;
        r3_re_term <= w2_re_prod[47:15];
        r3_im_term <= w2_im_prod[47:15];
        r3_re_neg  <= r2_re_neg;
        r3_im_neg  <= r2_im_neg;
    end

    // A read that meets the write of the item ahead of it takes the written word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_fwd <= 1'b0;
        end else begin
            r3_fwd <= w3_write && r2_valid && (r2_slot == r3_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w3_write) begin
            r_last_wr <= {w3_re_sat, w3_im_sat};
        end
    end

    // Accumulate and clamp to the 32-bit range.
    assign w3_acc   = r3_fwd ? r_last_wr : r3_rd_data;
    assign w3_write = r3_valid && r3_tag.in_range;

    always_comb begin
        w3_re = 35'($signed(w3_acc[63:32])) +
                (r3_re_neg ? -35'($signed({2'b00, r3_re_term})) : 35'($signed({2'b00, r3_re_term})));
        w3_im = 35'($signed(w3_acc[31:0])) +
                (r3_im_neg ? -35'($signed({2'b00, r3_im_term})) : 35'($signed({2'b00, r3_im_term})));
        w3_re_clip = 1'b0;
        w3_im_clip = 1'b0;
        w3_re_sat  = w3_re[31:0];
        w3_im_sat  = w3_im[31:0];
        if (w3_re > 35'sd2147483647) begin
            w3_re_sat  = 32'h7FFF_FFFF;
            w3_re_clip = 1'b1;
        end else if (w3_re < -35'sd2147483648) begin
            w3_re_sat  = 32'h8000_0000;
            w3_re_clip = 1'b1;
        end
        if (w3_im > 35'sd2147483647) begin
            w3_im_sat  = 32'h7FFF_FFFF;
            w3_im_clip = 1'b1;
        end else if (w3_im < -35'sd2147483648) begin
            w3_im_sat  = 32'h8000_0000;
            w3_im_clip = 1'b1;
        end
    end

    // Result word; cells outside the plane report zero sums.
    always_comb begin
        o_out_push               = r3_valid;
        o_out_word.out_component = r3_tag.component;
        o_out_word.out_cell_i    = r3_tag.cell_i;
        o_out_word.out_cell_j    = r3_tag.cell_j;
        o_out_word.sum_real      = r3_tag.in_range ? w3_re_sat : 32'd0;
        o_out_word.sum_imag      = r3_tag.in_range ? w3_im_sat : 32'd0;
        o_out_word.saturated     = r3_tag.in_range && (w3_re_clip || w3_im_clip);
    end

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Accumulator memory ports.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_store[r_clr_addr] <= 64'd0;
        end else if (w3_write) begin
            r_store[r3_slot] <= {w3_re_sat, w3_im_sat};
        end
        r3_rd_data <= r_store[r2_slot];
    end

`ifndef SYNTHESIS
    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !w_issue)
        else $error("item issued during clearing pass");
    a_slot_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w3_write |-> (32'(r3_slot) < 32'(STORE_DEPTH)))
        else $error("accumulator address beyond store");
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_fwd |-> $past(w3_write))
        else $error("forward without a preceding write");
    a_fwd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_fwd |-> (r3_slot == $past(r3_slot)))
        else $error("forward to a different accumulator");
`endif
endmodule
`default_nettype wire

// File: design/plane_phasor_accumulator_unit.sv
// Top level of the plane phasor accumulator: ports, configuration and queues.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+-----------------------------
//  input    | in        | push / full             | i_in_word  (t_in_word)
//  result   | out       | pop / empty             | o_out_word (t_out_word)
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// In steady state one word is accepted per cycle while full is low, and one result leaves per cycle while pop is held.
// A pushed word passes the middle queue and the back pipeline stages before its result enters
// the result queue; the accumulator read-modify-write forwards between neighboring words of one cell.
// After reset the accumulator memory is cleared, one entry per cycle, over all
// 4*(MAX_CELLS_I+1)*(MAX_CELLS_J+1) entries (16900 at the defaults); full is high then.
// The back part only starts a word when the result queue can hold all words in flight.
`timescale 1ns / 1ps
`default_nettype none
module plane_phasor_accumulator_unit #(
    parameter int MAX_CELLS_I   = ppa_pkg::MAX_CELLS_I_DEF,
    parameter int MAX_CELLS_J   = ppa_pkg::MAX_CELLS_J_DEF,
    parameter int PHASE_ENTRIES = ppa_pkg::PHASE_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire ppa_pkg::t_in_word               i_in_word,
    input  wire logic                            pop,
    output logic                                 empty,
    output ppa_pkg::t_out_word                   o_out_word,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ppa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);
    localparam int MCW = $clog2(ppa_pkg::MID_DEPTH + 1);
    localparam int OCW = $clog2(ppa_pkg::OUT_DEPTH + 1);

    ppa_pkg::t_cfg      r_cfg;
    ppa_pkg::t_work     w_front_work;
    ppa_pkg::t_work     w_mid_work;
    logic               w_mid_full;
    logic               w_mid_empty;
    logic               w_mid_pop;
    logic [MCW-1:0]     w_mid_count;
    logic               w_clearing;
    logic               w_out_push;
    logic               w_out_full;
    logic [OCW-1:0]     w_out_count;
    ppa_pkg::t_out_word w_out_word;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= ppa_pkg::PHASE_STEP_RST;
            r_cfg.inverse_steps <= ppa_pkg::INVERSE_STEPS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ppa_pkg::REG_PHASE_STEP:    r_cfg.phase_step    <= i_cfg_data;
                ppa_pkg::REG_INVERSE_STEPS: r_cfg.inverse_steps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input side is full while the memory clears.
    assign full = w_mid_full || w_clearing;

    ppa_front #(
        .MAX_CELLS_I (MAX_CELLS_I),
        .MAX_CELLS_J (MAX_CELLS_J)
    ) u_front (
        .i_word       (i_in_word),
        .i_phase_step (r_cfg.phase_step),
        .o_work       (w_front_work)
    );

    ppa_fifo #(
        .WIDTH ($bits(ppa_pkg::t_work)),
        .DEPTH (ppa_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (w_front_work),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_work),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    ppa_back #(
        .MAX_CELLS_I   (MAX_CELLS_I),
        .MAX_CELLS_J   (MAX_CELLS_J),
        .PHASE_ENTRIES (PHASE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_inverse_steps (r_cfg.inverse_steps),
        .i_work          (w_mid_work),
        .i_work_empty    (w_mid_empty),
        .o_work_pop      (w_mid_pop),
        .i_out_count     (w_out_count),
        .o_out_push      (w_out_push),
        .o_out_word      (w_out_word),
        .o_clearing      (w_clearing)
    );

    ppa_fifo #(
        .WIDTH ($bits(ppa_pkg::t_out_word)),
        .DEPTH (ppa_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_word),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_out_word),
        .o_empty (empty),
        .o_count (w_out_count)
    );

`ifndef SYNTHESIS
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result dropped at a full result queue");
    a_mid_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (w_mid_count == '0))
        else $error("words queued during clearing pass");
`endif
endmodule
`default_nettype wire
